@@ hw/rtl/dsv_pkg.sv @@
// date string validator package: result codes, field limits, state record
// and the small arithmetic helpers shared by the field and verdict modules
// no dependencies
package dsv_pkg;

    localparam int unsigned DAY_W   = 7;
    localparam int unsigned MONTH_W = 7;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MOD25_W = 5;

    localparam logic [DAY_W-1:0]   DAY_MAX   = 7'd127;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 7'd127;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 12'd4095;

    // residue of the saturated year, worked out at elaboration
    localparam logic [MOD25_W-1:0] YEAR_SAT_MOD25 = MOD25_W'(4095 % 25);

    localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 12'd1900;
    localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 12'd2100;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_FMT   = 3'd1;
    localparam t_status ST_YEAR  = 3'd2;
    localparam t_status ST_MONTH = 3'd3;
    localparam t_status ST_DAY   = 3'd4;

    localparam logic CFG_MIN_YEAR = 1'b0;
    localparam logic CFG_MAX_YEAR = 1'b1;

    localparam logic [1:0] FIELD_DAY   = 2'd0;
    localparam logic [1:0] FIELD_MONTH = 2'd1;
    localparam logic [1:0] FIELD_YEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]         field_index;
        logic [DAY_W-1:0]   day_value;
        logic [MONTH_W-1:0] month_value;
        logic [YEAR_W-1:0]  year_value;
        logic [MOD25_W-1:0] year_mod25;
        logic [2:0]         field_nonempty;
        logic               format_bad;
    } t_date_state;

    // v*10 + d saturating at 127, for day and month
    function automatic logic [6:0] acc7(input logic [6:0] v, input logic [3:0] d);
        logic [10:0] s;
        s = {4'b0, v} * 11'd10 + {7'b0, d};
        return (s > 11'd127) ? 7'd127 : s[6:0];
    endfunction

    // residue mod 25 of a value below 250, by reciprocal multiply
    function automatic logic [4:0] mod25_8(input logic [7:0] v);
        logic [13:0] p;
        logic [3:0]  q;
        logic [7:0]  r;
        p = {6'b0, v} * 14'd41;
        q = p[13:10];
        r = v - 8'({4'b0, q} * 8'd25);
        return r[4:0];
    endfunction

    function automatic logic [4:0] month_length(input logic [6:0] m, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        if (m == 7'd4 || m == 7'd6 || m == 7'd9 || m == 7'd11) begin
            len = 5'd30;
        end else if (m == 7'd2) begin
            len = leap ? 5'd29 : 5'd28;
        end
        return len;
    endfunction

endpackage

@@ hw/rtl/dsv_fields.sv @@
// date string validator field tracker: slash count, saturating field values,
// year residue mod 25 and format flags; depends on dsv_pkg
module dsv_fields import dsv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_char,
    input  logic        i_last,
    output t_date_state o_next
);

    t_date_state r_st;
    t_date_state n_st;

    logic        is_slash;
    logic        is_digit;
    logic [3:0]  digit;
    logic [15:0] year_sum;
    logic [7:0]  mod_sum;

    assign is_slash = (i_char == CH_SLASH);
    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign digit    = 4'(i_char - CH_ZERO);
    assign year_sum = {4'b0, r_st.year_value} * 16'd10 + {12'b0, digit};
    assign mod_sum  = {3'b0, r_st.year_mod25} * 8'd10 + {4'b0, digit};

    always_comb begin
        n_st = r_st;
        if (is_slash) begin
            if (r_st.field_index != FIELD_YEAR) begin
                n_st.field_index = r_st.field_index + 2'd1;
            end else begin
                n_st.format_bad = 1'b1;
            end
        end else if (is_digit) begin
            unique case (r_st.field_index)
                FIELD_DAY:   n_st.day_value   = acc7(r_st.day_value, digit);
                FIELD_MONTH: n_st.month_value = acc7(r_st.month_value, digit);
                default: begin
                    if (year_sum > {4'b0, YEAR_MAX}) begin
                        n_st.year_value = YEAR_MAX;
                        n_st.year_mod25 = YEAR_SAT_MOD25;
                    end else begin
                        n_st.year_value = year_sum[11:0];
                        n_st.year_mod25 = mod25_8(mod_sum);
                    end
                end
            endcase
            n_st.field_nonempty = r_st.field_nonempty | (3'b001 << r_st.field_index);
        end else begin
            n_st.format_bad = 1'b1;
        end
    end

    assign o_next = n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_st <= '0;
            end else begin
                r_st <= n_st;
            end
        end
    end

endmodule

@@ hw/rtl/dsv_verdict.sv @@
// date string validator verdict: format, year, month and day checks in
// priority order with gregorian leap rule; depends on dsv_pkg
module dsv_verdict import dsv_pkg::*; (
    input  t_date_state        i_st,
    input  logic [YEAR_W-1:0]  i_min_year,
    input  logic [YEAR_W-1:0]  i_max_year,
    output t_status            o_status
);

    logic div4;
    logic div25;
    logic leap;
    logic [4:0] mlen;

    // divisible by 100 is div4 and div25, by 400 is div16 and div25
    assign div4  = (i_st.year_value[1:0] == 2'b00);
    assign div25 = (i_st.year_mod25 == '0);
    assign leap  = (div25 && i_st.year_value[3:0] == 4'b0000) || (div4 && !div25);
    assign mlen  = month_length(i_st.month_value, leap);

    always_comb begin
        priority if (i_st.format_bad || i_st.field_index != FIELD_YEAR
                     || i_st.field_nonempty != 3'b111) begin
            o_status = ST_FMT;
        end else if (i_st.year_value < i_min_year || i_st.year_value > i_max_year) begin
            o_status = ST_YEAR;
        end else if (i_st.month_value == '0 || i_st.month_value > 7'd12) begin
            o_status = ST_MONTH;
        end else if (i_st.day_value == '0 || i_st.day_value > {2'b0, mlen}) begin
            o_status = ST_DAY;
        end else begin
            o_status = ST_OK;
        end
    end

endmodule

@@ hw/rtl/date_string_validator_core.sv @@
// date string validator top level: input register, field tracker, verdict
// logic and result register; depends on dsv_pkg, dsv_fields, dsv_verdict
//
// takes a day/month/year date string one ascii character per request, the
// final character flagged by i_is_last, and returns one status per string:
// ok, format error, year outside [min_year, max_year], month outside 1..12 or
// day beyond the month length (gregorian leap years). characters that are not
// last give no result. throughput is one character per clock unless a final
// character stalls: the character is held in an input register, the field
// update and all checks are combinational, and a string's status lands in
// an output register once its last character leaves the input register, and
// waits there until the output side collects it.
// non-final characters keep flowing while a status waits to be collected;
// only a final character is held in the input register until the previous
// status has gone. year limits are written through the plain config port
// (index 0 min_year, index 1 max_year), by the user only while no string is
// in flight (not enforced by the block); both reset to 1900 and 2100
module date_string_validator_core import dsv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character requests
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_is_last,
    // status results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    // year limit registers
    logic [YEAR_W-1:0] r_min_year;
    logic [YEAR_W-1:0] r_max_year;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= MIN_YEAR_RST;
            r_max_year <= MAX_YEAR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_YEAR: r_min_year <= i_cfg_data;
                default:      r_max_year <= i_cfg_data;
            endcase
        end
    end

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       s1_adv;

    // a non-final character always moves on, a final one needs a free result slot
    assign s1_adv     = r_in_valid && (!r_in_last || !o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_char <= i_char_code;
            r_in_last <= i_is_last;
        end
    end

    // field tracking and verdict
    t_date_state st_next;
    t_status     status_next;

    dsv_fields u_fields (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_adv),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_next  (st_next)
    );

    dsv_verdict u_verdict (
        .i_st       (st_next),
        .i_min_year (r_min_year),
        .i_max_year (r_max_year),
        .o_status   (status_next)
    );

    // result register
    logic    r_out_valid;
    logic    n_out_valid;
    t_status r_status;
    logic    res_load;

    assign res_load    = s1_adv && r_in_last;
    assign n_out_valid = (r_out_valid && !i_out_ready) || res_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_status <= status_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    // a fresh result only follows a final character leaving the input register
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_in_valid && r_in_last))
        else $error("result appeared without a final character");

    // a stalled final character keeps its place
    a_input_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !s1_adv) |=> (r_in_valid && $stable(r_in_char) && $stable(r_in_last)))
        else $error("input register lost a stalled character");

    // slash count never passes the year field
    a_field_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_next.field_index != 2'd3)
        else $error("field index out of range");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status <= ST_DAY))
        else $error("undefined status code");

endmodule
